/* rtl/assert_macros.svh */
// Assertion macros shared by the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/tsms_pkg.sv */
// Types, constants and helpers of the track sector mark scanner.
`default_nettype none
package tsms_pkg;

  localparam int MAX_SECTOR_RECORDS = 32;
  localparam int MAX_TRACK_BYTES    = 8192;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [5:0]  COUNT_CAP = 6'(MAX_SECTOR_RECORDS > 63 ? 63 : MAX_SECTOR_RECORDS);
  localparam logic [12:0] POS_MAX   = 13'(MAX_TRACK_BYTES - 1);

  localparam logic [7:0] ID_MARK_RESET      = 8'hFE;
  localparam logic [7:0] DATA_MARK_RESET    = 8'hFB;
  localparam logic [7:0] DELETED_MARK_RESET = 8'hF8;

  typedef enum logic [1:0] {
    MODE_HUNT_ID,
    MODE_ID_FIELD,
    MODE_HUNT_DATA,
    MODE_SKIP_DATA
  } scan_mode_t;

  typedef enum logic [1:0] {
    REG_ID_MARK,
    REG_DATA_MARK,
    REG_DELETED_MARK
  } cfg_reg_t;

  typedef enum logic {
    KIND_SECTOR  = 1'b0,
    KIND_SUMMARY = 1'b1
  } record_kind_t;

  typedef struct packed {
    logic [7:0] track_byte;
    logic       track_end;
  } in_word_t;

  typedef struct packed {
    logic        record_kind;
    logic [4:0]  sector_index;
    logic [12:0] id_offset;
    logic [7:0]  cylinder;
    logic [7:0]  head;
    logic [7:0]  record_number;
    logic [7:0]  size_code;
    logic [12:0] data_offset;
    logic        data_found;
    logic        deleted;
    logic [5:0]  sector_count;
    logic        last;
  } out_word_t;

  // One queue entry carries everything a single track byte caused.
  typedef struct packed {
    logic       has_sector;
    logic       has_summary;
    out_word_t  sector;
    logic [5:0] count;
  } qentry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

  // Bytes to skip after a data mark: 2^(N+7)+2 more, N clamped to 7.
  function automatic logic [14:0] skip_len(input logic [7:0] size);
    logic [2:0] nc;
    logic [3:0] sh;
    nc = (size > 8'd7) ? 3'd7 : size[2:0];
    sh = {1'b0, nc} + 4'd7;
    return (15'd1 << sh) + 15'd2;
  endfunction

endpackage
`default_nettype wire

/* rtl/track_sector_mark_scanner.sv */
// Top level of the track sector mark scanner.
`default_nettype none
// The scanner takes one track byte per cycle with no bubbles while the result
// queue has room; each byte's scan step is one pass through the front state
// machine. Results leave at one word per cycle from the output register while
// out_stall is low, so a byte that ends a track with a pending sector needs two
// output words (sector, then summary). A four-entry queue between front and back
// absorbs those bursts and output stalls; input stall rises only when that queue
// is full. Mark registers are written through cfg_write/cfg_index/cfg_data and
// take effect on the next byte; indexes past the deleted mark are ignored.
module track_sector_mark_scanner (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tsms_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tsms_pkg::out_word_t     out_data
);
  import tsms_pkg::*;

  logic          push;
  qentry_t       push_data;
  logic          pop;
  qentry_t       head;
  queue_status_t q_status;

  tsms_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  tsms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  tsms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* rtl/tsms_front.sv */
// Front end: mark registers, byte classification and the scan state machine.
`default_nettype none
module tsms_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tsms_pkg::in_word_t in_data,
  input  wire tsms_pkg::queue_status_t q_status,
  output logic                    push,
  output tsms_pkg::qentry_t       push_data
);
  import tsms_pkg::*;

  logic [7:0] id_mark;
  logic [7:0] data_mark;
  logic [7:0] deleted_mark;

  scan_mode_t  mode, mode_next;
  logic [12:0] pos, pos_next;
  logic [14:0] skip, skip_next;
  logic [12:0] hoff, hoff_next;
  logic [7:0]  fields [4];
  logic [7:0]  fields_next [4];
  logic [5:0]  count, count_next;
  logic [4:0]  hidx, hidx_next;
  logic        hvalid, hvalid_next;
  logic        data_hit;
  logic        data_del;
  logic        nodata;
  logic        accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  // Write the mark registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      id_mark      <= ID_MARK_RESET;
      data_mark    <= DATA_MARK_RESET;
      deleted_mark <= DELETED_MARK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ID_MARK:      id_mark      <= cfg_data;
        REG_DATA_MARK:    data_mark    <= cfg_data;
        REG_DELETED_MARK: deleted_mark <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Hold scan state; advance it on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_HUNT_ID;
      pos    <= '0;
      skip   <= '0;
      hoff   <= '0;
      fields <= '{default: 8'd0};
      count  <= '0;
      hidx   <= '0;
      hvalid <= 1'b0;
    end else if (accept) begin
      mode   <= mode_next;
      pos    <= pos_next;
      skip   <= skip_next;
      hoff   <= hoff_next;
      fields <= fields_next;
      count  <= count_next;
      hidx   <= hidx_next;
      hvalid <= hvalid_next;
    end
  end

  // Next scan state and the queue entry for this word.
  always_comb begin
    mode_next   = mode;
    skip_next   = skip;
    hoff_next   = hoff;
    fields_next = fields;
    count_next  = count;
    hidx_next   = hidx;
    hvalid_next = hvalid;
    data_hit    = 1'b0;
    data_del    = 1'b0;
    pos_next    = (pos == POS_MAX) ? pos : pos + 13'd1;

    unique case (mode)
      MODE_HUNT_ID: begin
        if (in_data.track_byte == id_mark) begin
          hoff_next   = pos;
          fields_next = '{default: 8'd0};
          if (count < COUNT_CAP) begin
            hidx_next   = count[4:0];
            hvalid_next = 1'b1;
            count_next  = count + 6'd1;
          end else begin
            hvalid_next = 1'b0;
          end
          skip_next = 15'd6;
          mode_next = MODE_ID_FIELD;
        end
      end
      MODE_ID_FIELD: begin
        if (skip >= 15'd3 && skip <= 15'd6) begin
          fields_next[2'(3'd6 - skip[2:0])] = in_data.track_byte;
        end
        if (skip <= 15'd1) begin
          skip_next = '0;
          mode_next = MODE_HUNT_DATA;
        end else begin
          skip_next = skip - 15'd1;
        end
      end
      MODE_HUNT_DATA: begin
        if (in_data.track_byte == data_mark || in_data.track_byte == deleted_mark) begin
          data_hit    = hvalid;
          data_del    = (in_data.track_byte == deleted_mark);
          hvalid_next = 1'b0;
          skip_next   = skip_len(fields[3]);
          mode_next   = MODE_SKIP_DATA;
        end
      end
      MODE_SKIP_DATA: begin
        if (skip <= 15'd1) begin
          skip_next = '0;
          mode_next = MODE_HUNT_ID;
        end else begin
          skip_next = skip - 15'd1;
        end
      end
      default: ;
    endcase

    // A sector still waiting for its data at track end goes out without data.
    nodata = in_data.track_end && hvalid_next &&
             (mode_next == MODE_ID_FIELD || mode_next == MODE_HUNT_DATA);

    push_data.has_sector           = data_hit || nodata;
    push_data.has_summary          = in_data.track_end;
    push_data.count                = count_next;
    push_data.sector.record_kind   = KIND_SECTOR;
    push_data.sector.sector_index  = hidx_next;
    push_data.sector.id_offset     = hoff_next;
    push_data.sector.cylinder      = fields_next[0];
    push_data.sector.head          = fields_next[1];
    push_data.sector.record_number = fields_next[2];
    push_data.sector.size_code     = fields_next[3];
    push_data.sector.data_offset   = data_hit ? pos : 13'd0;
    push_data.sector.data_found    = data_hit;
    push_data.sector.deleted       = data_hit && data_del;
    push_data.sector.sector_count  = 6'd0;
    push_data.sector.last          = !in_data.track_end;

    // Return to the reset scan state after the last word of a track.
    if (in_data.track_end) begin
      mode_next   = MODE_HUNT_ID;
      pos_next    = '0;
      skip_next   = '0;
      hoff_next   = '0;
      fields_next = '{default: 8'd0};
      count_next  = '0;
      hidx_next   = '0;
      hvalid_next = 1'b0;
    end
  end

  assign push = accept && (push_data.has_sector || push_data.has_summary);

endmodule
`default_nettype wire

/* rtl/tsms_queue.sv */
// Short queue of per-word result entries between front and back.
`default_nettype none
`include "assert_macros.svh"
module tsms_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire tsms_pkg::qentry_t     push_data,
  input  wire logic                  pop,
  output tsms_pkg::qentry_t          head,
  output tsms_pkg::queue_status_t    status
);
  import tsms_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  qentry_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;

  // Store pushed entries.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  assign head             = entries[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.full      = (count == (PTR_W+1)'(QUEUE_DEPTH));

  `ASSERT_CLK(no_overflow, status.full |-> !push, "push into a full queue")
  `ASSERT_CLK(no_underflow, !status.not_empty |-> !pop, "pop from an empty queue")

endmodule
`default_nettype wire

/* rtl/tsms_back.sv */
// Back end: splits queue entries into result words and holds the output register.
`default_nettype none
`include "assert_macros.svh"
module tsms_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire tsms_pkg::qentry_t       head,
  input  wire tsms_pkg::queue_status_t q_status,
  output logic                         pop,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output tsms_pkg::out_word_t          out_data
);
  import tsms_pkg::*;

  logic      phase;
  logic      load;
  logic      send_sector;
  out_word_t summary;

  assign load        = !out_valid || !out_stall;
  assign send_sector = head.has_sector && !phase;
  assign pop         = load && q_status.not_empty && !(send_sector && head.has_summary);

  // Build the end of track summary word.
  always_comb begin
    summary              = '0;
    summary.record_kind  = KIND_SUMMARY;
    summary.sector_count = head.count;
    summary.last         = 1'b1;
  end

  // Hold the output word until taken; load the next one from the queue head.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= q_status.not_empty;
      if (q_status.not_empty) begin
        phase <= send_sector && head.has_summary;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_status.not_empty) begin
      out_data <= send_sector ? head.sector : summary;
    end
  end

  `ASSERT_CLK(phase_has_pair, phase |-> (q_status.not_empty && head.has_sector && head.has_summary),
              "second half pending without a sector and summary entry")
  `ASSERT_CLK(summary_is_last, (out_valid && out_data.record_kind) |-> out_data.last,
              "summary word not marked last")

endmodule
`default_nettype wire

/* dv/track_sector_mark_scanner_test.sv */
// Self-checking testbench of the track sector mark scanner: directed rows, random tracks.
module track_sector_mark_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tsms_pkg::*;

  localparam int SECTOR_CAP   = (MAX_SECTOR_RECORDS > 63) ? 63 : MAX_SECTOR_RECORDS;
  localparam int LAST_POS     = MAX_TRACK_BYTES - 1;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_BYTES  = 160;

  // Ways a generated track may be cut short by its end flag
  typedef enum int {
    CUT_NONE,
    CUT_IN_ID,
    CUT_HUNT_DATA,
    CUT_ON_MARK,
    CUT_IN_SKIP
  } track_cut_t;

  // One directed row: the word to send and, where typed in, its records
  typedef struct packed {
    logic [7:0] byte_val;
    logic       end_flag;
    logic       typed;
    logic [1:0] n_typed;
    out_word_t  r0;
    out_word_t  r1;
  } step_row_t;

  localparam out_word_t NONE = '0;
  localparam out_word_t SUM0 = '{record_kind: KIND_SUMMARY, last: 1'b1, default: '0};
  localparam out_word_t SUM1 = '{record_kind: KIND_SUMMARY, sector_count: 6'd1, last: 1'b1,
                                 default: '0};
  localparam out_word_t BARE = '{record_kind: KIND_SECTOR, default: '0};
  localparam out_word_t SDEL = '{record_kind: KIND_SECTOR, sector_index: 5'd0, id_offset: 13'd1,
                                 cylinder: 8'hFF, head: 8'h00, record_number: 8'h7F,
                                 size_code: 8'h00, data_offset: 13'd9, data_found: 1'b1,
                                 deleted: 1'b1, sector_count: 6'd0, last: 1'b1};

  localparam step_row_t PLAN [25] = '{
    // single-byte tracks right after reset
    '{8'h00, 1'b1, 1'b1, 2'd1, SUM0, NONE},
    '{8'hFF, 1'b1, 1'b1, 2'd1, SUM0, NONE},
    '{8'hFE, 1'b1, 1'b1, 2'd2, BARE, SUM1},
    // full ID, ignored ID mark while hunting data, deleted mark, end in skip
    '{8'h00, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'hFE, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'hFF, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h00, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h7F, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h00, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'hFE, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'hFB, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'hFE, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'hF8, 1'b0, 1'b1, 2'd1, SDEL, NONE},
    '{8'hFB, 1'b1, 1'b1, 2'd1, SUM1, NONE},
    // ID field cut by the track end
    '{8'hFE, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h12, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h34, 1'b1, 1'b0, 2'd0, NONE, NONE},
    // largest size code, track ends on the data mark
    '{8'hFE, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h01, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h80, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h05, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'hFF, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h00, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'h00, 1'b0, 1'b0, 2'd0, NONE, NONE},
    '{8'hFB, 1'b1, 1'b0, 2'd0, NONE, NONE}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;

  // Scanner model state and mark registers
  scan_mode_t  sc_mode;
  logic [12:0] sc_pos;
  logic [14:0] sc_skip;
  logic [12:0] sc_id_off;
  logic [7:0]  sc_id [4];
  logic [5:0]  sc_found;
  logic [5:0]  sc_index;
  logic        sc_held;
  logic [7:0]  mk_id;
  logic [7:0]  mk_data;
  logic [7:0]  mk_del;

  out_word_t   byte_records [$];
  out_word_t   awaited_records [$];
  in_word_t    track_buf [$];

  bit          steady;
  int          mismatches;
  int          records_checked;
  int          bytes_sent;
  int          tracks_sent;
  int          reg_writes;

  track_sector_mark_scanner i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Return the model to the start of a track
  task automatic clear_scan();
    sc_mode   = MODE_HUNT_ID;
    sc_pos    = '0;
    sc_skip   = '0;
    sc_id_off = '0;
    sc_id     = '{default: '0};
    sc_found  = '0;
    sc_index  = '0;
    sc_held   = 1'b0;
  endtask

  function automatic out_word_t sector_word(input logic [12:0] data_pos, input logic found,
                                            input logic del);
    out_word_t rec;
    rec               = '0;
    rec.record_kind   = KIND_SECTOR;
    rec.sector_index  = sc_index[4:0];
    rec.id_offset     = sc_id_off;
    rec.cylinder      = sc_id[0];
    rec.head          = sc_id[1];
    rec.record_number = sc_id[2];
    rec.size_code     = sc_id[3];
    rec.data_offset   = found ? data_pos : '0;
    rec.data_found    = found;
    rec.deleted       = found && del;
    return rec;
  endfunction

  // Advance the scanner model by one track byte; its records land in byte_records
  task automatic scan_track_byte(input in_word_t w);
    logic [7:0] b;
    out_word_t  rec;
    int         nc;
    byte_records.delete();
    b = w.track_byte;
    case (sc_mode)
      MODE_HUNT_ID: begin
        if (b == mk_id) begin
          sc_id_off = sc_pos;
          sc_id     = '{default: '0};
          if (int'(sc_found) < SECTOR_CAP) begin
            sc_index = sc_found;
            sc_held  = 1'b1;
            sc_found++;
          end else begin
            sc_held = 1'b0;
          end
          sc_skip = 15'd6;
          sc_mode = MODE_ID_FIELD;
        end
      end
      MODE_ID_FIELD: begin
        if (sc_skip >= 3 && sc_skip <= 6) sc_id[2'(6 - sc_skip)] = b;
        if (sc_skip <= 1) begin
          sc_skip = '0;
          sc_mode = MODE_HUNT_DATA;
        end else begin
          sc_skip--;
        end
      end
      MODE_HUNT_DATA: begin
        if (b == mk_data || b == mk_del) begin
          if (sc_held) byte_records.push_back(sector_word(sc_pos, 1'b1, b == mk_del));
          sc_held = 1'b0;
          nc      = (sc_id[3] > 8'd7) ? 7 : int'(sc_id[3]);
          sc_skip = 15'((1 << (nc + 7)) + 2);
          sc_mode = MODE_SKIP_DATA;
        end
      end
      default: begin
        if (sc_skip <= 1) begin
          sc_skip = '0;
          sc_mode = MODE_HUNT_ID;
        end else begin
          sc_skip--;
        end
      end
    endcase
    if (int'(sc_pos) < LAST_POS) sc_pos++;
    // Flush a pending sector, then the summary, and start over
    if (w.track_end) begin
      if ((sc_mode == MODE_ID_FIELD || sc_mode == MODE_HUNT_DATA) && sc_held)
        byte_records.push_back(sector_word('0, 1'b0, 1'b0));
      rec              = '0;
      rec.record_kind  = KIND_SUMMARY;
      rec.sector_count = sc_found;
      byte_records.push_back(rec);
      clear_scan();
    end
    if (byte_records.size() > 0) byte_records[$].last = 1'b1;
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Random byte with marks sprinkled in, optionally steering clear of some marks
  function automatic logic [7:0] fill_byte(input bit no_id, input bit no_data);
    logic [7:0] b;
    do begin
      case ($urandom_range(0, 11))
        0:       b = mk_id;
        1:       b = mk_data;
        2:       b = mk_del;
        default: b = 8'($urandom_range(0, 255));
      endcase
    end while ((no_id && b == mk_id) || (no_data && (b == mk_data || b == mk_del)));
    return b;
  endfunction

  // Send one word at the falling edge and hold it until accepted
  task automatic send_word(input in_word_t w, input bit typed, input int n_typed,
                           input out_word_t r0, input out_word_t r1);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    scan_track_byte(w);
    if (typed) begin
      awaited_records.push_back(r0);
      if (n_typed > 1) awaited_records.push_back(r1);
    end else begin
      foreach (byte_records[i]) awaited_records.push_back(byte_records[i]);
    end
    bytes_sent++;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    track_buf.push_back('{track_byte: b, track_end: 1'b0});
  endtask

  task automatic send_track();
    track_buf[$].track_end = 1'b1;
    foreach (track_buf[i]) send_word(track_buf[i], 1'b0, 0, NONE, NONE);
    tracks_sent++;
  endtask

  // Build a well-formed track of n_sec sectors, the last one possibly cut short
  task automatic build_track(input int n_sec, input track_cut_t cut);
    logic [7:0] size;
    bit         final_sec;
    int         nc;
    track_buf.delete();
    for (int s = 0; s < n_sec; s++) begin
      final_sec = (s == n_sec - 1);
      repeat ($urandom_range(0, 4)) push_byte(fill_byte(1'b1, 1'b0));
      push_byte(mk_id);
      if (final_sec && cut == CUT_IN_ID) begin
        repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
        break;
      end
      repeat (3) push_byte(8'($urandom_range(0, 255)));
      if (final_sec && cut == CUT_IN_SKIP) size = 8'($urandom_range(2, 255));
      else size = ($urandom_range(0, 7) == 0) ? 8'd1 : 8'd0;
      push_byte(size);
      repeat (2) push_byte(8'($urandom_range(0, 255)));
      if (final_sec && cut == CUT_HUNT_DATA) begin
        repeat ($urandom_range(0, 3)) push_byte(fill_byte(1'b0, 1'b1));
        break;
      end
      repeat ($urandom_range(0, 4)) push_byte(fill_byte(1'b0, 1'b1));
      push_byte($urandom_range(0, 1) ? mk_data : mk_del);
      if (final_sec && cut == CUT_ON_MARK) break;
      if (final_sec && cut == CUT_IN_SKIP) begin
        repeat ($urandom_range(0, 6)) push_byte(fill_byte(1'b0, 1'b0));
        break;
      end
      // Skipped data may hold anything; the bytes after it must not open a sector
      nc = (size > 8'd7) ? 7 : int'(size);
      repeat ((1 << (nc + 7)) + 2) push_byte(fill_byte(1'b0, 1'b0));
      repeat ($urandom_range(0, 2)) push_byte(fill_byte(1'b1, 1'b0));
    end
    if (cut == CUT_NONE) repeat ($urandom_range(0, 3)) push_byte(fill_byte(1'b1, 1'b0));
    if (track_buf.size() == 0) push_byte(fill_byte(1'b1, 1'b0));
    send_track();
  endtask

  // Random tracks until the byte budget of the phase is spent
  task automatic run_random_phase();
    int start_bytes;
    int r;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < PHASE_BYTES) begin
      steady = ($urandom_range(0, 4) == 0);
      r      = $urandom_range(0, 99);
      if (r < 50) begin
        build_track($urandom_range(1, 3), CUT_NONE);
      end else if (r < 75) begin
        build_track($urandom_range(1, 3), track_cut_t'($urandom_range(1, 4)));
      end else if (r < 90) begin
        track_buf.delete();
        repeat ($urandom_range(1, 24)) push_byte(fill_byte(1'b0, 1'b0));
        send_track();
      end else begin
        build_track(0, CUT_NONE);
      end
    end
    steady = 1'b0;
  endtask

  // Drop valid and wait until the scanner has nothing left in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_records.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_ID_MARK:   mk_id   = value;
      REG_DATA_MARK: mk_data = value;
      default:       mk_del  = value;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    reg_writes++;
  endtask

  task automatic set_marks(input logic [7:0] id_v, input logic [7:0] data_v,
                           input logic [7:0] del_v);
    write_reg(REG_ID_MARK, id_v);
    write_reg(REG_DATA_MARK, data_v);
    write_reg(REG_DELETED_MARK, del_v);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted record with the oldest expectation
  always @(posedge clk) begin : watch_records
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_records.size() == 0) begin
        $error("record arrived with nothing expected");
        mismatches++;
      end else begin
        want = awaited_records.pop_front();
        check_field("record_kind", want.record_kind, out_data.record_kind);
        check_field("sector_index", want.sector_index, out_data.sector_index);
        check_field("id_offset", want.id_offset, out_data.id_offset);
        check_field("cylinder", want.cylinder, out_data.cylinder);
        check_field("head", want.head, out_data.head);
        check_field("record_number", want.record_number, out_data.record_number);
        check_field("size_code", want.size_code, out_data.size_code);
        check_field("data_offset", want.data_offset, out_data.data_offset);
        check_field("data_found", want.data_found, out_data.data_found);
        check_field("deleted", want.deleted, out_data.deleted);
        check_field("sector_count", want.sector_count, out_data.sector_count);
        check_field("last", want.last, out_data.last);
        records_checked++;
      end
    end
  end

  // Output back-pressure: short stalls, a few long ones, and quiet stretches
  initial begin : drive_out_stall
    int run;
    int len;
    out_stall = 1'b0;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 6);
      repeat (run) @(negedge clk);
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 30);
      out_stall <= 1'b1;
      repeat (len) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  initial begin : watchdog
    #(20_000_000);
    $display("FAIL track_sector_mark_scanner");
    $finish;
  end

  initial begin : stimulus
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = REG_ID_MARK;
    cfg_data  = '0;
    mk_id     = ID_MARK_RESET;
    mk_data   = DATA_MARK_RESET;
    mk_del    = DELETED_MARK_RESET;
    clear_scan();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows with the reset marks
    foreach (PLAN[i])
      send_word('{track_byte: PLAN[i].byte_val, track_end: PLAN[i].end_flag}, PLAN[i].typed,
                PLAN[i].n_typed, PLAN[i].r0, PLAN[i].r1);

    // Random tracks under several mark settings
    run_random_phase();
    settle();
    set_marks(8'h00, 8'hFF, 8'hFF);
    run_random_phase();
    settle();
    set_marks(8'hFF, 8'h00, 8'h80);
    run_random_phase();
    settle();
    set_marks(8'h5A, 8'h5A, 8'hA5);
    run_random_phase();
    settle();
    set_marks(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    run_random_phase();
    settle();

    $display("Sent %0d track bytes in %0d tracks, checked %0d records, wrote %0d mark registers.",
             bytes_sent, tracks_sent, records_checked, reg_writes);
    $display("Runs covered equal and extreme marks, sectors cut at every stage, stalls both ways.");
    if (mismatches == 0) begin
      $display("PASS track_sector_mark_scanner");
    end else begin
      $display("FAIL track_sector_mark_scanner");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tsms_pkg.sv
rtl/tsms_front.sv
rtl/tsms_queue.sv
rtl/tsms_back.sv
rtl/track_sector_mark_scanner.sv
dv/track_sector_mark_scanner_test.sv
